/* rtl/core/sfps_pkg.sv */
// shared types, codes and helpers for the spi flash page sequencer
package sfps_pkg;

    localparam int PAGE_BYTES_DEF = 256;

    // input item kinds
    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    // host command codes
    localparam logic [1:0] OPC_ERASE = 2'd0;
    localparam logic [1:0] OPC_PROG  = 2'd1;
    localparam logic [1:0] OPC_READ  = 2'd2;

    // result actions
    localparam logic [1:0] ACT_XCHG    = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_DATA    = 2'd2;
    localparam logic [1:0] ACT_DONE    = 2'd3;

    // flash instruction bytes
    localparam logic [7:0] SPI_WREN   = 8'h06;
    localparam logic [7:0] SPI_ERASE  = 8'hD8;
    localparam logic [7:0] SPI_PROG   = 8'h02;
    localparam logic [7:0] SPI_READ   = 8'h03;
    localparam logic [7:0] SPI_STATUS = 8'h05;
    localparam logic [7:0] SPI_FILL   = 8'h00;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] mosi;
        logic       from_mem;
        logic [7:0] data;
        logic [7:0] idx;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res [2:0] ent;
    } t_res_set;

    function automatic t_res mk_res(input logic [1:0] action, input logic [7:0] mosi);
        t_res r;
        r = '0;
        r.action = action;
        r.mosi = mosi;
        return r;
    endfunction

    function automatic t_res_set res_push(input t_res_set s, input t_res e);
        t_res_set r;
        r = s;
        case (s.cnt)
            2'd0: begin
                r.ent[0] = e;
                r.cnt = 2'd1;
            end
            2'd1: begin
                r.ent[1] = e;
                r.cnt = 2'd2;
            end
            2'd2: begin
                r.ent[2] = e;
                r.cnt = 2'd3;
            end
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/sfps_store.sv */
// page store: single-port write, registered single read
module sfps_store import sfps_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    localparam int AW = $clog2(PAGE_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [PAGE_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/sfps_ctrl.sv */
// command sequencer state and per-request result builder
module sfps_ctrl import sfps_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    localparam int AW = $clog2(PAGE_BYTES),
    localparam int CW = $clog2(PAGE_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [1:0]    i_kind,
    input  logic [1:0]    i_opcode,
    input  logic [15:0]   i_page,
    input  logic [7:0]    i_load_index,
    input  logic [7:0]    i_load_byte,
    input  logic [7:0]    i_reply_byte,
    output t_res_set      o_res,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_WREN      = 4'd1;
    localparam logic [3:0] PH_CMD       = 4'd2;
    localparam logic [3:0] PH_ADDR_HI   = 4'd3;
    localparam logic [3:0] PH_ADDR_LO   = 4'd4;
    localparam logic [3:0] PH_ADDR_Z    = 4'd5;
    localparam logic [3:0] PH_DATA      = 4'd6;
    localparam logic [3:0] PH_STAT_CMD  = 4'd7;
    localparam logic [3:0] PH_STAT_POLL = 4'd8;

    logic [3:0]    r_phase, n_phase;
    logic [1:0]    r_op, n_op;
    logic [15:0]   r_page, n_page;
    logic [CW-1:0] r_bc, n_bc;

    logic [CW-1:0] bc_inc;
    logic [CW+7:0] bc_ext;
    logic [AW+7:0] li_ext;
    logic [7:0]    cmd_code;
    t_res_set      res;
    t_res          ent;

    assign bc_inc = r_bc + CW'(1);
    assign bc_ext = {8'b0, r_bc};
    assign li_ext = {{AW{1'b0}}, i_load_index};

    always_comb begin
        case (r_op)
            OPC_ERASE: cmd_code = SPI_ERASE;
            OPC_PROG:  cmd_code = SPI_PROG;
            default:   cmd_code = SPI_READ;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_op = r_op;
        n_page = r_page;
        n_bc = r_bc;
        res = '0;
        ent = '0;
        o_wr_en = 1'b0;
        o_rd_en = 1'b0;
        o_rd_addr = '0;
        if (i_fire) begin
            case (i_kind)
                KIND_CMD: begin
                    if (r_phase == PH_IDLE && i_opcode <= OPC_READ) begin
                        n_op = i_opcode;
                        n_page = i_page;
                        n_bc = '0;
                        if (i_opcode == OPC_READ) begin
                            res = res_push(res, mk_res(ACT_XCHG, SPI_READ));
                            n_phase = PH_CMD;
                        end else begin
                            res = res_push(res, mk_res(ACT_XCHG, SPI_WREN));
                            n_phase = PH_WREN;
                        end
                    end
                end
                KIND_LOAD: begin
                    o_wr_en = 1'b1;
                end
                KIND_REPLY: begin
                    case (r_phase)
                        PH_WREN: begin
                            res = res_push(res, mk_res(ACT_RELEASE, 8'h00));
                            res = res_push(res, mk_res(ACT_XCHG, cmd_code));
                            n_phase = PH_CMD;
                        end
                        PH_CMD: begin
                            res = res_push(res, mk_res(ACT_XCHG, r_page[15:8]));
                            n_phase = PH_ADDR_HI;
                        end
                        PH_ADDR_HI: begin
                            res = res_push(res, mk_res(ACT_XCHG, r_page[7:0]));
                            n_phase = PH_ADDR_LO;
                        end
                        PH_ADDR_LO: begin
                            res = res_push(res, mk_res(ACT_XCHG, SPI_FILL));
                            n_phase = PH_ADDR_Z;
                        end
                        PH_ADDR_Z: begin
                            if (r_op == OPC_ERASE) begin
                                res = res_push(res, mk_res(ACT_RELEASE, 8'h00));
                                res = res_push(res, mk_res(ACT_XCHG, SPI_STATUS));
                                n_phase = PH_STAT_CMD;
                            end else begin
                                n_bc = '0;
                                ent = mk_res(ACT_XCHG, SPI_FILL);
                                ent.from_mem = (r_op == OPC_PROG);
                                o_rd_en = (r_op == OPC_PROG);
                                res = res_push(res, ent);
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            if (r_op == OPC_READ) begin
                                ent = mk_res(ACT_DATA, 8'h00);
                                ent.data = i_reply_byte;
                                ent.idx = bc_ext[7:0];
                                res = res_push(res, ent);
                            end
                            if (bc_inc < CW'(PAGE_BYTES)) begin
                                n_bc = bc_inc;
                                ent = mk_res(ACT_XCHG, SPI_FILL);
                                ent.from_mem = (r_op == OPC_PROG);
                                o_rd_en = (r_op == OPC_PROG);
                                o_rd_addr = bc_inc[AW-1:0];
                                res = res_push(res, ent);
                            end else begin
                                n_bc = '0;
                                res = res_push(res, mk_res(ACT_RELEASE, 8'h00));
                                res = res_push(res, mk_res(ACT_XCHG, SPI_STATUS));
                                n_phase = PH_STAT_CMD;
                            end
                        end
                        PH_STAT_CMD: begin
                            res = res_push(res, mk_res(ACT_XCHG, SPI_FILL));
                            n_phase = PH_STAT_POLL;
                        end
                        PH_STAT_POLL: begin
                            if (i_reply_byte != 8'h00) begin
                                res = res_push(res, mk_res(ACT_XCHG, SPI_FILL));
                            end else begin
                                res = res_push(res, mk_res(ACT_RELEASE, 8'h00));
                                res = res_push(res, mk_res(ACT_DONE, 8'h00));
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op <= OPC_ERASE;
            r_page <= '0;
            r_bc <= '0;
        end else begin
            r_phase <= n_phase;
            r_op <= n_op;
            r_page <= n_page;
            r_bc <= n_bc;
        end
    end

    assign o_res = res;
    assign o_wr_addr = li_ext[AW-1:0];
    assign o_wr_data = i_load_byte;

endmodule

/* rtl/core/sfps_outbuf.sv */
// result holding register: drains one request's results one per cycle while i_ready is high
module sfps_outbuf import sfps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_res_set   i_res,
    input  logic [7:0] i_mem_data,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_action,
    output logic [7:0] o_mosi_byte,
    output logic [7:0] o_page_data,
    output logic [7:0] o_read_index,
    output logic       o_last_of_run
);

    logic       r_valid;
    t_res_set   r_set;
    logic [1:0] r_slot;
    t_res       cur;
    logic       pop;
    logic       last;

    always_comb begin
        case (r_slot)
            2'd0:    cur = r_set.ent[0];
            2'd1:    cur = r_set.ent[1];
            default: cur = r_set.ent[2];
        endcase
    end

    assign last = (r_slot == r_set.cnt - 2'd1);
    assign pop = r_valid && i_ready;
    assign o_free = !r_valid || (pop && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot <= 2'd0;
        end else if (i_fire && i_res.cnt != 2'd0) begin
            r_valid <= 1'b1;
            r_slot <= 2'd0;
        end else if (pop && last) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_slot <= r_slot + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_res.cnt != 2'd0) begin
            r_set <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_action = cur.action;
    assign o_mosi_byte = cur.from_mem ? i_mem_data : cur.mosi;
    assign o_page_data = cur.data;
    assign o_read_index = cur.idx;
    assign o_last_of_run = last;

endmodule

/* rtl/core/spi_flash_page_sequencer.sv */
// spi nor flash page sequencer top level: control, page store and result buffer
// latency: the first result of a request is offered the cycle after it is accepted
// throughput: a request holds the result buffer until its last result leaves; the next
//   request is taken in that cycle: one a cycle at one result each if i_out_ready is high
// page store read (program data) is issued at acceptance and lands with the result
// reset: synchronous active low, clears sequencer state and the result buffer;
//   the page store is not cleared and needs no clearing pass
module spi_flash_page_sequencer import sfps_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_page,
    input  logic [7:0]  i_load_index,
    input  logic [7:0]  i_load_byte,
    input  logic [7:0]  i_reply_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action,
    output logic [7:0]  o_mosi_byte,
    output logic [7:0]  o_page_data,
    output logic [7:0]  o_read_index,
    output logic        o_last_of_run
);

    // page store address width; PAGE_BYTES is taken as a power of two
    localparam int AW = $clog2(PAGE_BYTES);

    logic          fire;
    logic          free;
    t_res_set      res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // a request is taken whenever the result buffer is empty or empties now
    assign o_in_ready = free;
    assign fire = i_in_valid && free;

    // sequencer: phase, command, page and byte counter; builds up to three results
    sfps_ctrl #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_kind       (i_kind),
        .i_opcode     (i_opcode),
        .i_page       (i_page),
        .i_load_index (i_load_index),
        .i_load_byte  (i_load_byte),
        .i_reply_byte (i_reply_byte),
        .o_res        (res),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr)
    );

    // page store; loads and program reads come from different requests, so a
    // read always sees every earlier load without forwarding
    sfps_store #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result buffer; read data stays put until the next accepted request,
    // which can only come once the program byte has left
    sfps_outbuf u_outbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_res         (res),
        .i_mem_data    (rd_data),
        .o_free        (free),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_action      (o_action),
        .o_mosi_byte   (o_mosi_byte),
        .o_page_data   (o_page_data),
        .o_read_index  (o_read_index),
        .o_last_of_run (o_last_of_run)
    );

    // no request is taken over results still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> !o_out_valid || (i_out_ready && o_last_of_run))
        else $error("request accepted over pending results");

    // only exchange results carry a shift byte
    a_mosi_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action != ACT_XCHG |-> o_mosi_byte == 8'h00)
        else $error("shift byte on a non-exchange result");

    // done always closes its request's results
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == ACT_DONE |-> o_last_of_run)
        else $error("done not last of run");

endmodule

/* tb/tb_spi_flash_page_sequencer.sv */
// self-checking testbench for the spi flash page sequencer: predictor, request driver, result checks

typedef enum logic [3:0] {
    FS_IDLE,
    FS_WREN,
    FS_CMD,
    FS_ADDR_HI,
    FS_ADDR_LO,
    FS_ADDR_Z,
    FS_DATA,
    FS_STAT_CMD,
    FS_STAT_POLL
} t_flash_phase;

typedef struct packed {
    logic [1:0] action;
    logic [7:0] mosi;
    logic [7:0] data;
    logic [7:0] idx;
    logic       last;
} t_spi_step;

// mirrors the sequencer state and holds the spi steps still owed by the block
class flash_op_tracker;
    t_flash_phase phase;
    logic [1:0]   op;
    logic [15:0]  page;
    int unsigned  count;
    logic [7:0]   store [sfps_pkg::PAGE_BYTES_DEF];
    t_spi_step    due_steps [$];
    int unsigned  failures;
    int unsigned  checked;

    function new();
        phase    = FS_IDLE;
        op       = sfps_pkg::OPC_ERASE;
        page     = 16'h0000;
        count    = 0;
        failures = 0;
        checked  = 0;
        foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endfunction

    function void add_step(logic [1:0] action, logic [7:0] mosi, logic [7:0] data,
                           logic [7:0] idx);
        t_spi_step s;
        s.action = action;
        s.mosi   = mosi;
        s.data   = data;
        s.idx    = idx;
        s.last   = 1'b0;
        due_steps.push_back(s);
    endfunction

    // release the command frame and open the status frame
    function void open_status();
        add_step(sfps_pkg::ACT_RELEASE, 8'h00, 8'h00, 8'h00);
        add_step(sfps_pkg::ACT_XCHG, sfps_pkg::SPI_STATUS, 8'h00, 8'h00);
        phase = FS_STAT_CMD;
    endfunction

    // program shifts out the page store, read shifts out filler
    function logic [7:0] data_byte();
        if (op == sfps_pkg::OPC_PROG) begin
            return store[count % sfps_pkg::PAGE_BYTES_DEF];
        end
        return sfps_pkg::SPI_FILL;
    endfunction

    function void take_request(logic [1:0] kind, logic [1:0] opc, logic [15:0] pg,
                               logic [7:0] li, logic [7:0] lb, logic [7:0] rb);
        int unsigned prior;
        t_spi_step   tail;
        prior = due_steps.size();
        case (kind)
            sfps_pkg::KIND_CMD: begin
                // busy or unknown opcode: dropped silently
                if (phase == FS_IDLE && opc <= sfps_pkg::OPC_READ) begin
                    op    = opc;
                    page  = pg;
                    count = 0;
                    if (opc == sfps_pkg::OPC_READ) begin
                        add_step(sfps_pkg::ACT_XCHG, sfps_pkg::SPI_READ, 8'h00, 8'h00);
                        phase = FS_CMD;
                    end else begin
                        add_step(sfps_pkg::ACT_XCHG, sfps_pkg::SPI_WREN, 8'h00, 8'h00);
                        phase = FS_WREN;
                    end
                end
            end
            sfps_pkg::KIND_LOAD: begin
                store[li] = lb;
            end
            sfps_pkg::KIND_REPLY: begin
                case (phase)
                    FS_WREN: begin
                        add_step(sfps_pkg::ACT_RELEASE, 8'h00, 8'h00, 8'h00);
                        add_step(sfps_pkg::ACT_XCHG,
                                 (op == sfps_pkg::OPC_ERASE) ? sfps_pkg::SPI_ERASE :
                                 (op == sfps_pkg::OPC_PROG)  ? sfps_pkg::SPI_PROG  :
                                                               sfps_pkg::SPI_READ,
                                 8'h00, 8'h00);
                        phase = FS_CMD;
                    end
                    FS_CMD: begin
                        add_step(sfps_pkg::ACT_XCHG, page[15:8], 8'h00, 8'h00);
                        phase = FS_ADDR_HI;
                    end
                    FS_ADDR_HI: begin
                        add_step(sfps_pkg::ACT_XCHG, page[7:0], 8'h00, 8'h00);
                        phase = FS_ADDR_LO;
                    end
                    FS_ADDR_LO: begin
                        add_step(sfps_pkg::ACT_XCHG, sfps_pkg::SPI_FILL, 8'h00, 8'h00);
                        phase = FS_ADDR_Z;
                    end
                    FS_ADDR_Z: begin
                        if (op == sfps_pkg::OPC_ERASE) begin
                            open_status();
                        end else begin
                            count = 0;
                            add_step(sfps_pkg::ACT_XCHG, data_byte(), 8'h00, 8'h00);
                            phase = FS_DATA;
                        end
                    end
                    FS_DATA: begin
                        if (op == sfps_pkg::OPC_READ) begin
                            add_step(sfps_pkg::ACT_DATA, 8'h00, rb, 8'(count));
                        end
                        count++;
                        if (count < sfps_pkg::PAGE_BYTES_DEF) begin
                            add_step(sfps_pkg::ACT_XCHG, data_byte(), 8'h00, 8'h00);
                        end else begin
                            count = 0;
                            open_status();
                        end
                    end
                    FS_STAT_CMD: begin
                        // the byte clocked in under the status opcode is not status
                        add_step(sfps_pkg::ACT_XCHG, sfps_pkg::SPI_FILL, 8'h00, 8'h00);
                        phase = FS_STAT_POLL;
                    end
                    FS_STAT_POLL: begin
                        if (rb != 8'h00) begin
                            add_step(sfps_pkg::ACT_XCHG, sfps_pkg::SPI_FILL, 8'h00, 8'h00);
                        end else begin
                            add_step(sfps_pkg::ACT_RELEASE, 8'h00, 8'h00, 8'h00);
                            add_step(sfps_pkg::ACT_DONE, 8'h00, 8'h00, 8'h00);
                            phase = FS_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        if (due_steps.size() > prior) begin
            tail = due_steps.pop_back();
            tail.last = 1'b1;
            due_steps.push_back(tail);
        end
    endfunction

    function void check_step(logic [1:0] action, logic [7:0] mosi, logic [7:0] data,
                             logic [7:0] idx, logic last);
        t_spi_step want;
        if (due_steps.size() == 0) begin
            flag($sformatf("unexpected result: action %0d mosi %02h data %02h idx %0d last %0d",
                           action, mosi, data, idx, last));
            return;
        end
        want = due_steps.pop_front();
        checked++;
        if (want.action !== action || want.mosi !== mosi || want.data !== data ||
            want.idx !== idx || want.last !== last) begin
            flag($sformatf({"result %0d: expected action %0d mosi %02h data %02h idx %0d ",
                            "last %0d, got action %0d mosi %02h data %02h idx %0d last %0d"},
                           checked, want.action, want.mosi, want.data, want.idx, want.last,
                           action, mosi, data, idx, last));
        end
    endfunction
endclass

module tb_spi_flash_page_sequencer;
    import sfps_pkg::*;

    // codes the block has no name for, used to poke the ignore paths
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [1:0] OPC_NONE  = 2'd3;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  kind       = KIND_CMD;
    logic [1:0]  opcode     = OPC_ERASE;
    logic [15:0] page       = 16'h0000;
    logic [7:0]  load_index = 8'h00;
    logic [7:0]  load_byte  = 8'h00;
    logic [7:0]  reply_byte = 8'h00;
    logic        out_valid;
    logic        out_ready  = 1'b1;
    logic [1:0]  action;
    logic [7:0]  mosi_byte;
    logic [7:0]  page_data;
    logic [7:0]  read_index;
    logic        last_of_run;

    logic [15:0] stall_pat  = 16'hFFFF;
    logic [3:0]  stall_slot = 4'd0;
    bit          quiet      = 1'b0;
    int unsigned burst_left = 0;

    int unsigned n_sent     = 0;
    int unsigned n_erase    = 0;
    int unsigned n_prog     = 0;
    int unsigned n_read     = 0;
    int unsigned n_stray    = 0;
    int unsigned n_busy     = 0;

    flash_op_tracker tracker;

    spi_flash_page_sequencer uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (kind),
        .i_opcode      (opcode),
        .i_page        (page),
        .i_load_index  (load_index),
        .i_load_byte   (load_byte),
        .i_reply_byte  (reply_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_action      (action),
        .o_mosi_byte   (mosi_byte),
        .o_page_data   (page_data),
        .o_read_index  (read_index),
        .o_last_of_run (last_of_run)
    );

    always #4 clk = ~clk;

    // result side stalls on a rotating random mask, always ready in quiet stretches
    always @(posedge clk) begin
        stall_slot <= stall_slot + 4'd1;
        if (stall_slot == 4'd15) begin
            stall_pat <= 16'($urandom);
        end
        out_ready <= quiet || stall_pat[stall_slot];
    end

    // check before noting, so a stray result is never matched to a fresh request
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                tracker.check_step(action, mosi_byte, page_data, read_index, last_of_run);
            end
            if (in_valid && in_ready) begin
                tracker.take_request(kind, opcode, page, load_index, load_byte, reply_byte);
            end
        end
    end

    // one request, sent in bursts with random gaps between them
    task automatic send_request(input logic [1:0] k, input logic [1:0] opc,
                                input logic [15:0] pg, input logic [7:0] li,
                                input logic [7:0] lb, input logic [7:0] rb);
        int unsigned gap;
        gap = 0;
        if (!quiet) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 7);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        opcode     <= opc;
        page       <= pg;
        load_index <= li;
        load_byte  <= lb;
        reply_byte <= rb;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
        n_sent++;
    endtask

    // flash reply; the other fields are don't-care and get random values
    task automatic send_reply(input logic [7:0] rb);
        send_request(KIND_REPLY, 2'($urandom), 16'($urandom), 8'($urandom),
                     8'($urandom), rb);
    endtask

    // an item that must leave the spi sequence untouched; a reply only while idle
    task automatic add_stray(input bit busy);
        int unsigned sel;
        sel = $urandom_range(0, 3);
        n_stray++;
        case (sel)
            0: send_request(KIND_CMD, busy ? 2'($urandom) : OPC_NONE, 16'($urandom),
                            8'($urandom), 8'($urandom), 8'($urandom));
            1: send_request(KIND_LOAD, 2'($urandom), 16'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom));
            2: send_request(KIND_NONE, 2'($urandom), 16'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom));
            default: begin
                if (busy) begin
                    send_request(KIND_NONE, OPC_NONE, 16'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                end else begin
                    send_reply(8'($urandom));
                end
            end
        endcase
    endtask

    task automatic maybe_stray(input int unsigned pct);
        if ($urandom_range(0, 99) < pct) begin
            add_stray(1'b1);
        end
    endtask

    // whole command: request, a rival command, every reply up to the zero status
    task automatic run_command(input logic [1:0] opc, input logic [15:0] pg,
                               input int unsigned polls, input logic [7:0] echo,
                               input int unsigned pct);
        int unsigned n_rep;
        case (opc)
            OPC_ERASE: n_erase++;
            OPC_PROG:  n_prog++;
            default:   n_read++;
        endcase
        n_rep = ((opc == OPC_READ) ? 0 : 1) + 4 + ((opc == OPC_ERASE) ? 0 : PAGE_BYTES_DEF);
        send_request(KIND_CMD, opc, pg, 8'($urandom), 8'($urandom), 8'($urandom));
        send_request(KIND_CMD, 2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
        n_stray++;
        for (int i = 0; i < n_rep; i++) begin
            maybe_stray(pct);
            send_reply(8'($urandom));
        end
        maybe_stray(pct);
        send_reply(echo);
        for (int p = 0; p < polls; p++) begin
            maybe_stray(pct);
            send_reply(8'($urandom_range(1, 255)));
            n_busy++;
        end
        maybe_stray(pct);
        send_reply(8'h00);
    endtask

    initial begin
        int unsigned mark;
        int unsigned guard;
        int unsigned pick;
        logic [1:0]  opc;
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignore paths while idle: reply, unknown kind, unknown opcode
        send_reply(8'hFF);
        send_request(KIND_NONE, OPC_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(KIND_CMD, OPC_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);

        // the page store has to be fully written before any program
        for (int i = 0; i < PAGE_BYTES_DEF; i++) begin
            send_request(KIND_LOAD, OPC_ERASE, 16'h0000, 8'(i),
                         (i == 0) ? 8'h00 : (i == PAGE_BYTES_DEF - 1) ? 8'hFF : 8'($urandom),
                         8'h00);
        end

        // top page erase with a zero echo under the status opcode, then a long busy poll
        run_command(OPC_ERASE, 16'hFFFF, 3, 8'h00, 0);
        // program and read with loads and rival items mixed in
        run_command(OPC_PROG, 16'h0000, 0, 8'hFF, 6);
        run_command(OPC_READ, 16'hA5C3, 1, 8'h5A, 6);
        send_reply(8'h00);

        // random commands, mostly well formed, some quiet stretches with no idling
        mark = n_sent;
        while (n_sent - mark < 100) begin
            quiet = ($urandom_range(0, 3) == 0);
            pick  = $urandom_range(0, 9);
            opc   = (pick < 6) ? OPC_ERASE : (pick < 8) ? OPC_PROG : OPC_READ;
            if ($urandom_range(0, 2) == 0) begin
                add_stray(1'b0);
            end
            run_command(opc, 16'($urandom), $urandom_range(0, 4), 8'($urandom), 5);
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        guard = 0;
        while (tracker.due_steps.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        if (tracker.due_steps.size() != 0) begin
            tracker.flag($sformatf("%0d expected results never arrived",
                                   tracker.due_steps.size()));
        end

        $display("covered %0d requests: %0d erase, %0d program, %0d read, %0d stray or ignored",
                 n_sent, n_erase, n_prog, n_read, n_stray);
        $display("checked %0d results, %0d busy status polls, %0d failures",
                 tracker.checked, n_busy, tracker.failures);
        if (tracker.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #4000000;
        $display("timeout: sequencer stopped making progress");
        $display("Test completed with failures");
        $finish;
    end

endmodule
